// ===== sv/srfr_pkg.sv =====
// Shared types, constants and helper functions of the servo reply frame receiver.
package srfr_pkg;

	localparam int unsigned FRAME_LEN = 6;
	localparam int unsigned NUM_IDS   = 4;

	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'h8005;
	localparam logic [15:0] POS_RAW_MIN = 16'h0080;
	localparam logic [15:0] POS_RAW_MAX = 16'h0F80;

	// Register indexes of the configuration port
	localparam logic [7:0] REG_POSITION_ID    = 8'd0;
	localparam logic [7:0] REG_CURRENT_ID     = 8'd1;
	localparam logic [7:0] REG_VOLTAGE_ID     = 8'd2;
	localparam logic [7:0] REG_TEMPERATURE_ID = 8'd3;

	localparam logic [7:0] RESET_POSITION_ID    = 8'd44;
	localparam logic [7:0] RESET_CURRENT_ID     = 8'd48;
	localparam logic [7:0] RESET_VOLTAGE_ID     = 8'd49;
	localparam logic [7:0] RESET_TEMPERATURE_ID = 8'd16;

	// Reply kinds
	localparam logic [1:0] KIND_POSITION    = 2'd0;
	localparam logic [1:0] KIND_CURRENT     = 2'd1;
	localparam logic [1:0] KIND_VOLTAGE     = 2'd2;
	localparam logic [1:0] KIND_TEMPERATURE = 2'd3;

	// Scale factors of the unit conversions
	localparam logic [18:0] POS_MUL      = 19'd125;
	localparam logic [18:0] POS_ROUND    = 19'd12;
	localparam logic [15:0] RECIP_THREE  = 16'd43691;
	localparam logic [16:0] POS_OFFSET   = 17'd10000;
	localparam logic [16:0] CURRENT_MUL  = 17'd20;
	localparam logic [16:0] VOLTAGE_MUL  = 17'd200;
	localparam logic [16:0] TEMP_OFFSET  = 17'd50;

	typedef logic [NUM_IDS-1:0][7:0] id_set_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] kind;
	} kind_hit_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHECK = 6'b000010,
		ST_CRC   = 6'b000100,
		ST_POS1  = 6'b001000,
		ST_POS2  = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	// Lowest kind wins when several registers hold the same ID
	function automatic kind_hit_t kind_lookup(input logic [7:0] b, input id_set_t ids);
		kind_hit_t r;
		r.hit  = 1'b0;
		r.kind = KIND_POSITION;
		for (int k = NUM_IDS - 1; k >= 0; k--) begin
			if (ids[k] == b) begin
				r.hit  = 1'b1;
				r.kind = 2'(k);
			end
		end
		return r;
	endfunction

	// One byte of the CRC-16, MSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int j = 0; j < 8; j++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== sv/srfr_if.sv =====
// Handshake channel interfaces of the servo reply frame receiver.
interface srfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface srfr_reply_if;
	logic               valid;
	logic               ready;
	logic [1:0]         reply_kind;
	logic [4:0]         actuator_index;
	logic signed [16:0] first_value;
	logic signed [16:0] second_value;

	modport source (output valid, output reply_kind, output actuator_index,
		output first_value, output second_value, input ready);
	modport sink (input valid, input reply_kind, input actuator_index,
		input first_value, input second_value, output ready);
endinterface

interface srfr_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/servo_reply_frame_receiver_core.sv =====
// Servo reply frame receiver: byte assembly, CRC check and unit conversion.
// A new byte is taken only in the idle state, once the previous byte has been handled;
// after a good frame the result word is registered via CHECK, CRC and EMIT, with POS1 and POS2
// in between for position; a frame whose actuator is out of range gives no word.
// A full output register holds the block until the word is taken.
// Reset loads the default reply IDs, empties the buffer and clears the output valid flag.
module servo_reply_frame_receiver_core #(
	parameter int unsigned NUM_ACTUATORS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	srfr_byte_if.sink     rx,
	srfr_reply_if.source  reply,
	srfr_cfg_if.sink      cfg
);

	srfr_pkg::state_t  state_q;
	srfr_pkg::id_set_t ids_q;

	logic [srfr_pkg::FRAME_LEN-1:0][7:0] frame_q;
	logic [2:0]  fill_q;
	logic        drop_q;
	logic [15:0] crc_q;
	logic [1:0]  crc_cnt_q;
	logic [1:0]  kind_q;
	logic [4:0]  idx_q;
	logic [18:0] pos_x_q;
	logic [31:0] pos_prod_q;

	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [4:0]  out_idx_q;
	logic [16:0] out_v1_q;
	logic [16:0] out_v2_q;

	srfr_pkg::kind_hit_t lead;
	logic [2:0]  wr_addr;
	logic [15:0] crc_next;
	logic [7:0]  idx_next;
	logic [15:0] pos_raw;
	logic [15:0] pos_clamp;
	logic [11:0] pos_d;
	logic [16:0] v1;
	logic [16:0] v2;
	logic        out_free;

	assign rx.ready  = (state_q == srfr_pkg::ST_IDLE);
	assign cfg.ready = 1'b1;

	assign reply.valid          = out_valid_q;
	assign reply.reply_kind     = out_kind_q;
	assign reply.actuator_index = out_idx_q;
	assign reply.first_value    = $signed(out_v1_q);
	assign reply.second_value   = $signed(out_v2_q);

	assign out_free = !out_valid_q || reply.ready;
	assign lead     = srfr_pkg::kind_lookup(frame_q[0], ids_q);
	assign wr_addr  = (fill_q >= 3'(srfr_pkg::FRAME_LEN)) ? 3'd0 : fill_q;
	assign crc_next = srfr_pkg::crc16_byte(crc_q, frame_q[{1'b0, crc_cnt_q}]);
	assign idx_next = frame_q[1] - 8'd1;

	always_comb begin
		pos_raw = {frame_q[2], frame_q[3]};
		if (pos_raw < srfr_pkg::POS_RAW_MIN) begin
			pos_clamp = srfr_pkg::POS_RAW_MIN;
		end else if (pos_raw > srfr_pkg::POS_RAW_MAX) begin
			pos_clamp = srfr_pkg::POS_RAW_MAX;
		end else begin
			pos_clamp = pos_raw;
		end
		pos_d = 12'(pos_clamp - srfr_pkg::POS_RAW_MIN);
	end

	always_comb begin
		case (kind_q)
			srfr_pkg::KIND_POSITION: begin
				v1 = 17'(pos_prod_q[31:17]) - srfr_pkg::POS_OFFSET;
				v2 = '0;
			end
			srfr_pkg::KIND_CURRENT: begin
				v1 = 17'(frame_q[2]) * srfr_pkg::CURRENT_MUL;
				v2 = 17'(frame_q[3]) * srfr_pkg::CURRENT_MUL;
			end
			srfr_pkg::KIND_VOLTAGE: begin
				v1 = 17'(frame_q[2]) * srfr_pkg::VOLTAGE_MUL;
				v2 = 17'(frame_q[3]) * srfr_pkg::VOLTAGE_MUL;
			end
			default: begin
				v1 = 17'(frame_q[2]) - srfr_pkg::TEMP_OFFSET;
				v2 = 17'(frame_q[3]) - srfr_pkg::TEMP_OFFSET;
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ids_q[0] <= srfr_pkg::RESET_POSITION_ID;
			ids_q[1] <= srfr_pkg::RESET_CURRENT_ID;
			ids_q[2] <= srfr_pkg::RESET_VOLTAGE_ID;
			ids_q[3] <= srfr_pkg::RESET_TEMPERATURE_ID;
		end else if (cfg.valid) begin
			case (cfg.index)
				srfr_pkg::REG_POSITION_ID:    ids_q[0] <= cfg.data;
				srfr_pkg::REG_CURRENT_ID:     ids_q[1] <= cfg.data;
				srfr_pkg::REG_VOLTAGE_ID:     ids_q[2] <= cfg.data;
				srfr_pkg::REG_TEMPERATURE_ID: ids_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srfr_pkg::ST_IDLE;
			fill_q      <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == srfr_pkg::ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (reply.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				srfr_pkg::ST_IDLE: begin
					if (rx.valid) begin
						fill_q  <= wr_addr + 3'd1;
						drop_q  <= 1'b0;
						state_q <= srfr_pkg::ST_CHECK;
					end
				end
				srfr_pkg::ST_CHECK: begin
					if (fill_q == 3'd0) begin
						state_q <= srfr_pkg::ST_IDLE;
					end else if (drop_q || !lead.hit) begin
						fill_q <= fill_q - 3'd1;
						drop_q <= 1'b0;
					end else if (fill_q < 3'(srfr_pkg::FRAME_LEN)) begin
						state_q <= srfr_pkg::ST_IDLE;
					end else begin
						state_q <= srfr_pkg::ST_CRC;
					end
				end
				srfr_pkg::ST_CRC: begin
					if (crc_cnt_q == 2'd3) begin
						if (crc_next == {frame_q[4], frame_q[5]}) begin
							fill_q <= '0;
							if (idx_next >= 8'(NUM_ACTUATORS)) begin
								state_q <= srfr_pkg::ST_IDLE;
							end else if (lead.kind == srfr_pkg::KIND_POSITION) begin
								state_q <= srfr_pkg::ST_POS1;
							end else begin
								state_q <= srfr_pkg::ST_EMIT;
							end
						end else begin
							drop_q  <= 1'b1;
							state_q <= srfr_pkg::ST_CHECK;
						end
					end
				end
				srfr_pkg::ST_POS1: state_q <= srfr_pkg::ST_POS2;
				srfr_pkg::ST_POS2: state_q <= srfr_pkg::ST_EMIT;
				srfr_pkg::ST_EMIT: begin
					if (out_free) begin
						state_q <= srfr_pkg::ST_IDLE;
					end
				end
				default: state_q <= srfr_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			srfr_pkg::ST_IDLE: begin
				if (rx.valid) begin
					frame_q[wr_addr] <= rx.rx_byte;
				end
			end
			srfr_pkg::ST_CHECK: begin
				if (fill_q != 3'd0 && (drop_q || !lead.hit)) begin
					for (int i = 0; i < srfr_pkg::FRAME_LEN - 1; i++) begin
						frame_q[i] <= frame_q[i+1];
					end
				end
				crc_q     <= srfr_pkg::CRC_INIT;
				crc_cnt_q <= '0;
			end
			srfr_pkg::ST_CRC: begin
				crc_q     <= crc_next;
				crc_cnt_q <= crc_cnt_q + 2'd1;
				kind_q    <= lead.kind;
				idx_q     <= idx_next[4:0];
			end
			srfr_pkg::ST_POS1: begin
				pos_x_q <= 19'(pos_d) * srfr_pkg::POS_MUL + srfr_pkg::POS_ROUND;
			end
			srfr_pkg::ST_POS2: begin
				// divide by 8 by shift, then by 3 through the reciprocal
				pos_prod_q <= 32'(pos_x_q[18:3]) * 32'(srfr_pkg::RECIP_THREE);
			end
			srfr_pkg::ST_EMIT: begin
				if (out_free) begin
					out_kind_q <= kind_q;
					out_idx_q  <= idx_q;
					out_v1_q   <= v1;
					out_v2_q   <= v2;
				end
			end
			default: ;
		endcase
	end

endmodule
